@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the task dispatcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ rtl/ptd_pkg.sv @@
// Package with the types and constants of the periodic task dispatcher.
package ptd_pkg;

	localparam int TASK_W      = 8;
	localparam int PER_W       = 16;
	localparam int NOW_W       = 31;
	localparam int SLOT_W      = 4;
	localparam int CNT_W       = 5;
	localparam int MAX_RESULTS = 16;
	localparam int N_W         = 5;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_TICK   = 2'd0;
	localparam kind_t KIND_CREATE = 2'd1;
	localparam kind_t KIND_DELETE = 2'd2;
	localparam kind_t KIND_CLEAR  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TSCAN,
		ST_DIV,
		ST_DSCAN,
		ST_DCHK,
		ST_RESP,
		ST_FLUSH
	} state_t;

endpackage

@@ rtl/ptd_ram.sv @@
// Generic single-port RAM with a registered read.
module ptd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ rtl/periodic_task_dispatcher_core.sv @@
// Top level of the periodic task dispatcher: slot table, scan sequencer and modulo unit.
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------------------
//  command   | start / busy         | kind, task_id, slot, period, now
//  result    | strobe (no stall)    | done_kind, due, due_slot, due_task, found, last
//
// Create and clear go straight from the accepting cycle to their result beat.
// Delete walks the slots through the table RAM port until a match or the last slot.
// A tick walks the slots, skipping disabled ones; for each enabled slot a shared
// restoring remainder unit works one bit of now per cycle, and the scan ends with
// one final beat.
// Reset clears the enable marks at once; the table RAM needs no clearing pass.
// Result beats last one cycle and cannot be held off; busy stays high until the last one.
module periodic_task_dispatcher_core
	import ptd_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        kind,
	input  logic [TASK_W-1:0] task_id,
	input  logic [SLOT_W-1:0] slot,
	input  logic [PER_W-1:0]  period,
	input  logic [NOW_W-1:0]  now,
	output logic              strobe,
	output logic [1:0]        done_kind,
	output logic              due,
	output logic [SLOT_W-1:0] due_slot,
	output logic [TASK_W-1:0] due_task,
	output logic              found,
	output logic              last
);

	`include "assert_macros.svh"

	localparam int IW = $clog2(SLOTS);

	state_t              state_q, state_d;
	logic [IW-1:0]       idx_q, idx_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [PER_W-1:0]    rem_q, rem_d;
	logic [N_W-1:0]      n_q, n_d;
	logic                pv_q, pv_d;
	logic                found_q, found_d;
	logic [SLOTS-1:0]    en_q, en_d;
	kind_t               kind_q;
	logic [TASK_W-1:0]   id_q;
	logic [NOW_W-1:0]    now_q;
	logic [SLOT_W-1:0]   pend_slot_q;
	logic [TASK_W-1:0]   pend_task_q;
	logic                pend_load;

	logic                ram_we;
	logic [IW-1:0]       ram_addr;
	logic [TASK_W+PER_W-1:0] ram_rdata;
	logic [TASK_W-1:0]   rd_task;
	logic [PER_W-1:0]    rd_per;

	logic [6:0]          slot_w;
	logic [6:0]          idx_w;
	logic [IW-1:0]       slot_a;
	logic                slot_ok;
	logic                idx_last;
	logic                accept;

	logic [PER_W:0]      shifted;
	logic [PER_W:0]      diff;
	logic [PER_W-1:0]    rem_new;

	assign slot_w   = 7'(slot);
	assign slot_a   = slot_w[IW-1:0];
	assign slot_ok  = slot_w < 7'(SLOTS);
	assign idx_w    = 7'(idx_q);
	assign idx_last = idx_q == IW'(SLOTS - 1);
	assign accept   = start && !busy;
	assign rd_task  = ram_rdata[TASK_W+PER_W-1:PER_W];
	assign rd_per   = ram_rdata[PER_W-1:0];

	// The shared remainder unit brings in one bit of now per cycle.
	assign shifted = {rem_q, now_q[cnt_q]};
	assign diff    = shifted - {1'b0, rd_per};
	assign rem_new = (shifted >= {1'b0, rd_per}) ? diff[PER_W-1:0] : shifted[PER_W-1:0];

	ptd_ram #(
		.WIDTH(TASK_W + PER_W),
		.DEPTH(SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata({task_id, period}),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		cnt_d     = cnt_q;
		rem_d     = rem_q;
		n_d       = n_q;
		pv_d      = pv_q;
		found_d   = found_q;
		en_d      = en_q;
		pend_load = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = idx_q;
		strobe    = 1'b0;
		done_kind = kind_q;
		due       = 1'b0;
		due_slot  = '0;
		due_task  = '0;
		found     = 1'b0;
		last      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ram_addr = slot_a;
				if (start) begin
					idx_d   = '0;
					n_d     = '0;
					pv_d    = 1'b0;
					found_d = 1'b0;
					case (kind)
						KIND_CREATE: begin
							ram_we = slot_ok;
							if (slot_ok) begin
								en_d[slot_a] = period != '0;
							end
							state_d = ST_RESP;
						end
						KIND_DELETE: state_d = ST_DSCAN;
						KIND_CLEAR: begin
							en_d    = '0;
							state_d = ST_RESP;
						end
						default: state_d = ST_TSCAN;
					endcase
				end
			end
			ST_TSCAN: begin
				if (en_q[idx_q]) begin
					rem_d   = '0;
					cnt_d   = CNT_W'(NOW_W - 1);
					state_d = ST_DIV;
				end else if (idx_last) begin
					state_d = pv_q ? ST_FLUSH : ST_RESP;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			ST_DIV: begin
				rem_d = rem_new;
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					if (rem_new == '0) begin
						if (pv_q) begin
							strobe   = 1'b1;
							due      = 1'b1;
							due_slot = pend_slot_q;
							due_task = pend_task_q;
						end
						pend_load = 1'b1;
						pv_d      = 1'b1;
						n_d       = n_q + N_W'(1);
						if (n_q == N_W'(MAX_RESULTS - 1) || idx_last) begin
							state_d = ST_FLUSH;
						end else begin
							idx_d   = idx_q + IW'(1);
							state_d = ST_TSCAN;
						end
					end else if (idx_last) begin
						state_d = pv_q ? ST_FLUSH : ST_RESP;
					end else begin
						idx_d   = idx_q + IW'(1);
						state_d = ST_TSCAN;
					end
				end
			end
			ST_DSCAN: begin
				if (en_q[idx_q]) begin
					state_d = ST_DCHK;
				end else if (idx_last) begin
					state_d = ST_RESP;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			ST_DCHK: begin
				if (rd_task == id_q) begin
					en_d[idx_q] = 1'b0;
					found_d     = 1'b1;
					state_d     = ST_RESP;
				end else if (idx_last) begin
					state_d = ST_RESP;
				end else begin
					idx_d   = idx_q + IW'(1);
					state_d = ST_DSCAN;
				end
			end
			ST_RESP: begin
				strobe  = 1'b1;
				last    = 1'b1;
				found   = found_q;
				state_d = ST_IDLE;
			end
			ST_FLUSH: begin
				strobe   = 1'b1;
				due      = 1'b1;
				due_slot = pend_slot_q;
				due_task = pend_task_q;
				last     = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			n_q     <= '0;
			pv_q    <= 1'b0;
			found_q <= 1'b0;
			en_q    <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			n_q     <= n_d;
			pv_q    <= pv_d;
			found_q <= found_d;
			en_q    <= en_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_d;
		if (accept) begin
			kind_q <= kind;
			id_q   <= task_id;
			now_q  <= now;
		end
		if (pend_load) begin
			pend_slot_q <= idx_w[SLOT_W-1:0];
			pend_task_q <= rd_task;
		end
	end

	assign busy = state_q != ST_IDLE;

	`ASSERT_NEVER(a_beat_only_busy, clk, arst_n, strobe && !busy)
	`ASSERT_CLK(a_accept_busy, clk, arst_n, accept |=> busy)
	`ASSERT_CLK(a_last_idle, clk, arst_n, (strobe && last) |=> !busy)
	`ASSERT_CLK(a_more_tick_due, clk, arst_n, (strobe && !last) |-> (due && done_kind == KIND_TICK))

endmodule
